[rtl/core/lav_pkg.sv]
// ---------------------------------------------------------------------------
// Look-at view matrix package
// Fixed-point widths, latencies, vector types and the saturation helper.
// ---------------------------------------------------------------------------
package lav_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DW        = 32;
   localparam int NV_W      = FRAC_BITS + 3;
   localparam int QB        = FRAC_BITS + 1;
   localparam int XP_W      = DW + 2;
   localparam int SAT_W     = DW + 4;
   localparam int PR_W      = NV_W + DW;
   localparam int DIV_W     = DW + FRAC_BITS + 1;
   localparam int SQ_STEPS  = DW;
   localparam int NRM_LAT   = SQ_STEPS + QB + 5;
   localparam int XP_LAT    = 2;
   localparam int DOT_LAT   = 3;

   localparam logic [1:0] ROW_LAST = 2'd3;

   typedef logic signed [DW-1:0]   fix_type;
   typedef logic signed [NV_W-1:0] nv_type;
   typedef logic signed [XP_W-1:0] xp_type;
   typedef fix_type fvec_type [3];
   typedef nv_type  nvec_type [3];
   typedef xp_type  xvec_type [3];

   localparam fix_type ONE_FIX = fix_type'(64'd1 << FRAC_BITS);

   function automatic fix_type sat_fix(input logic signed [SAT_W-1:0] x);
      fix_type r;
      if (x[SAT_W-1:DW-1] == '0 || x[SAT_W-1:DW-1] == '1) begin
         r = x[DW-1:0];
      end else if (x[SAT_W-1]) begin
         r = {1'b1, {(DW-1){1'b0}}};
      end else begin
         r = {1'b0, {(DW-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

[rtl/core/look_at_view_matrix.sv]
// ---------------------------------------------------------------------------
// Look-at view matrix
// Builds the four rows of a look-at view matrix from eye, direction and up.
//
//   Channel   Handshake        Contents
//   request   start / busy     eye, direction and up vectors, Q16.16
//   result    rsp_strobe       row index, four columns, last-row flag
//
// A request is taken only while not busy; the four-row output sets the busy
// period after each one. The four rows leave on consecutive cycles, delayed
// from the request by the two chains of square root and division. Reset is
// synchronous and clears the valid bits. The receiver cannot stall, so the
// pipeline never holds.
// ---------------------------------------------------------------------------
module look_at_view_matrix (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lav_pkg::fix_type req_eye_x,
   input  lav_pkg::fix_type req_eye_y,
   input  lav_pkg::fix_type req_eye_z,
   input  lav_pkg::fix_type req_dir_x,
   input  lav_pkg::fix_type req_dir_y,
   input  lav_pkg::fix_type req_dir_z,
   input  lav_pkg::fix_type req_up_x,
   input  lav_pkg::fix_type req_up_y,
   input  lav_pkg::fix_type req_up_z,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_row_index,
   output lav_pkg::fix_type rsp_col0,
   output lav_pkg::fix_type rsp_col1,
   output lav_pkg::fix_type rsp_col2,
   output lav_pkg::fix_type rsp_col3,
   output logic             rsp_last_row
);
   import lav_pkg::*;

   localparam int FWD_DL = NRM_LAT + 7;
   localparam int EYE_DL = 2 * NRM_LAT + 4;

   logic [1:0] gap_ff;
   logic       accept;
   logic       req_vld_ff;
   fvec_type   req_eye_ff;
   fvec_type   req_dir_ff;
   fvec_type   req_up_ff;
   xvec_type   dir_ext;

   logic     fwd_vld;
   nvec_type fwd;
   logic     sraw_vld;
   xvec_type sraw;
   logic     side_vld;
   nvec_type side;
   fvec_type side_ext;
   logic     top_vld;
   xvec_type top;
   nvec_type top_nv;
   logic     dot_vld [3];
   fix_type  dot_r [3];

   fvec_type up_dl_ff   [NRM_LAT];
   nvec_type fwd_dl_ff  [FWD_DL];
   nvec_type side_dl_ff [5];
   xvec_type top_dl_ff  [3];
   fvec_type eye_dl_ff  [EYE_DL];

   logic       load;
   logic       oact_ff;
   logic [1:0] ocnt_ff;
   fix_type    ms_ff [3];
   fix_type    mt_ff [3];
   fix_type    mf_ff [3];
   fix_type    m3_ff [3];

   logic       rsp_strobe_ff;
   logic [1:0] rsp_row_ff;
   fix_type    rsp_c0_ff;
   fix_type    rsp_c1_ff;
   fix_type    rsp_c2_ff;
   fix_type    rsp_c3_ff;
   logic       rsp_last_ff;

   assign busy   = (gap_ff != 2'd0);
   assign accept = start && !busy;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dir_ext[i]  = xp_type'(req_dir_ff[i]);
         side_ext[i] = fix_type'(side[i]);
         top_nv[i]   = top[i][NV_W-1:0];
      end
   end

   lav_nrm u_nrm_fwd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_vld_ff),
      .in_vec    (dir_ext),
      .out_valid (fwd_vld),
      .out_vec   (fwd)
   );

   lav_cross u_cross_side (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fwd_vld),
      .a         (fwd),
      .b         (up_dl_ff[NRM_LAT-1]),
      .out_valid (sraw_vld),
      .r         (sraw)
   );

   lav_nrm u_nrm_side (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sraw_vld),
      .in_vec    (sraw),
      .out_valid (side_vld),
      .out_vec   (side)
   );

   lav_cross u_cross_top (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (side_vld),
      .a         (fwd_dl_ff[NRM_LAT+1]),
      .b         (side_ext),
      .out_valid (top_vld),
      .r         (top)
   );

   lav_dot u_dot_side (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (top_vld),
      .a         (side_dl_ff[1]),
      .b         (eye_dl_ff[EYE_DL-1]),
      .out_valid (dot_vld[0]),
      .r         (dot_r[0])
   );

   lav_dot u_dot_top (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (top_vld),
      .a         (top_nv),
      .b         (eye_dl_ff[EYE_DL-1]),
      .out_valid (dot_vld[1]),
      .r         (dot_r[1])
   );

   lav_dot u_dot_fwd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (top_vld),
      .a         (fwd_dl_ff[NRM_LAT+3]),
      .b         (eye_dl_ff[EYE_DL-1]),
      .out_valid (dot_vld[2]),
      .r         (dot_r[2])
   );

   assign load = dot_vld[0] && dot_vld[1] && dot_vld[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff        <= 2'd0;
         req_vld_ff    <= 1'b0;
         oact_ff       <= 1'b0;
         ocnt_ff       <= 2'd0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         req_vld_ff <= accept;
         if (accept) begin
            gap_ff <= 2'd3;
         end else if (gap_ff != 2'd0) begin
            gap_ff <= gap_ff - 2'd1;
         end
         rsp_strobe_ff <= oact_ff;
         if (load) begin
            oact_ff <= 1'b1;
            ocnt_ff <= 2'd0;
         end else if (oact_ff) begin
            ocnt_ff <= ocnt_ff + 2'd1;
            if (ocnt_ff == ROW_LAST) begin
               oact_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_eye_ff <= '{req_eye_x, req_eye_y, req_eye_z};
         req_dir_ff <= '{req_dir_x, req_dir_y, req_dir_z};
         req_up_ff  <= '{req_up_x, req_up_y, req_up_z};
      end
      up_dl_ff[0]   <= req_up_ff;
      eye_dl_ff[0]  <= req_eye_ff;
      fwd_dl_ff[0]  <= fwd;
      side_dl_ff[0] <= side;
      top_dl_ff[0]  <= top;
      for (int k = 1; k < NRM_LAT; k++) begin
         up_dl_ff[k] <= up_dl_ff[k-1];
      end
      for (int k = 1; k < EYE_DL; k++) begin
         eye_dl_ff[k] <= eye_dl_ff[k-1];
      end
      for (int k = 1; k < FWD_DL; k++) begin
         fwd_dl_ff[k] <= fwd_dl_ff[k-1];
      end
      for (int k = 1; k < 5; k++) begin
         side_dl_ff[k] <= side_dl_ff[k-1];
      end
      for (int k = 1; k < 3; k++) begin
         top_dl_ff[k] <= top_dl_ff[k-1];
      end
      if (load) begin
         for (int i = 0; i < 3; i++) begin
            ms_ff[i] <= fix_type'(side_dl_ff[4][i]);
            mt_ff[i] <= sat_fix(SAT_W'(top_dl_ff[2][i]));
            mf_ff[i] <= fix_type'(fwd_dl_ff[FWD_DL-1][i]);
            m3_ff[i] <= dot_r[i];
         end
      end
      rsp_row_ff <= ocnt_ff;
      case (ocnt_ff)
         2'd0: begin
            rsp_c0_ff <= ms_ff[0];
            rsp_c1_ff <= mt_ff[0];
            rsp_c2_ff <= mf_ff[0];
         end
         2'd1: begin
            rsp_c0_ff <= ms_ff[1];
            rsp_c1_ff <= mt_ff[1];
            rsp_c2_ff <= mf_ff[1];
         end
         2'd2: begin
            rsp_c0_ff <= ms_ff[2];
            rsp_c1_ff <= mt_ff[2];
            rsp_c2_ff <= mf_ff[2];
         end
         default: begin
            rsp_c0_ff <= m3_ff[0];
            rsp_c1_ff <= m3_ff[1];
            rsp_c2_ff <= m3_ff[2];
         end
      endcase
      rsp_c3_ff   <= (ocnt_ff == ROW_LAST) ? ONE_FIX : '0;
      rsp_last_ff <= (ocnt_ff == ROW_LAST);
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_col0      = rsp_c0_ff;
   assign rsp_col1      = rsp_c1_ff;
   assign rsp_col2      = rsp_c2_ff;
   assign rsp_col3      = rsp_c3_ff;
   assign rsp_last_row  = rsp_last_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken without the following busy period");

   a_rows_in_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_row) |=>
         (rsp_strobe && rsp_row_index == $past(rsp_row_index) + 2'd1))
      else $error("matrix rows not delivered on consecutive cycles");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_last_row == (rsp_row_index == ROW_LAST)))
      else $error("last-row flag disagrees with the row index");

   a_col3_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_row) |-> (rsp_col3 == '0))
      else $error("column three of an upper row is not zero");

endmodule

[rtl/core/lav_nrm.sv]
// ---------------------------------------------------------------------------
// Vector normaliser
// Pre-shift, squares, sum, a square-root pipeline of one bit per stage and
// three restoring dividers of one quotient bit per stage.
// ---------------------------------------------------------------------------
module lav_nrm (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  lav_pkg::xvec_type in_vec,
   output logic              out_valid,
   output lav_pkg::nvec_type out_vec
);
   import lav_pkg::*;

   logic [NRM_LAT-1:0] vld_ff;

   logic signed [DW-1:0] w_in [3];
   logic signed [DW-1:0] w_ff [3];

   logic [DW-1:0]   a1_in [3];
   logic [DW-1:0]   a1_ff [3];
   logic [2*DW-1:0] sq_in [3];
   logic [2*DW-1:0] sq_ff [3];
   logic [2:0]      sg1_ff;

   logic [2*DW-1:0] sum_in;
   logic [2*DW-1:0] sum_ff;
   logic [DW-1:0]   a2_ff [3];
   logic [2:0]      sg2_ff;

   logic [2*DW-1:0] rt_n_in [SQ_STEPS];
   logic [2*DW-1:0] rt_r_in [SQ_STEPS];
   logic [2*DW-1:0] rt_n_ff [SQ_STEPS];
   logic [2*DW-1:0] rt_r_ff [SQ_STEPS];
   logic [DW-1:0]   rt_a_ff [SQ_STEPS][3];
   logic [2:0]      rt_s_ff [SQ_STEPS];

   logic [DW-1:0]    m_w;
   logic [DIV_W-1:0] dd_in [3];
   logic [DIV_W-1:0] dd_ff [3];
   logic [DW-1:0]    dm_ff;
   logic [2:0]       ds_ff;
   logic             dz_ff;

   logic [DIV_W-1:0] dq_r_in [QB][3];
   logic [QB-1:0]    dq_q_in [QB][3];
   logic [DIV_W-1:0] dq_r_ff [QB][3];
   logic [QB-1:0]    dq_q_ff [QB][3];
   logic [DW-1:0]    dq_m_ff [QB];
   logic [2:0]       dq_s_ff [QB];
   logic             dq_z_ff [QB];

   nv_type o_in [3];
   nv_type o_ff [3];

   logic [2:0] fit0;
   logic [2:0] fit1;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fit0[i] = (in_vec[i][XP_W-1:DW-1] == '0) || (in_vec[i][XP_W-1:DW-1] == '1);
         fit1[i] = (in_vec[i][XP_W-1:DW] == '0) || (in_vec[i][XP_W-1:DW] == '1);
      end
      for (int i = 0; i < 3; i++) begin
         if (&fit0) begin
            w_in[i] = in_vec[i][DW-1:0];
         end else if (&fit1) begin
            w_in[i] = in_vec[i][DW:1];
         end else begin
            w_in[i] = in_vec[i][DW+1:2];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a1_in[i] = w_ff[i][DW-1] ? DW'(-w_ff[i]) : DW'(w_ff[i]);
         sq_in[i] = a1_in[i] * a1_in[i];
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_comb begin
      logic [2*DW-1:0] np;
      logic [2*DW-1:0] rp;
      logic [2*DW-1:0] bt;
      logic [2*DW-1:0] t;
      for (int k = 0; k < SQ_STEPS; k++) begin
         if (k == 0) begin
            np = sum_ff;
            rp = '0;
         end else begin
            np = rt_n_ff[k-1];
            rp = rt_r_ff[k-1];
         end
         bt = (2*DW)'(1) << (2 * (SQ_STEPS - 1 - k));
         t  = rp + bt;
         if (np >= t) begin
            rt_n_in[k] = np - t;
            rt_r_in[k] = (rp >> 1) + bt;
         end else begin
            rt_n_in[k] = np;
            rt_r_in[k] = rp >> 1;
         end
      end
   end

   assign m_w = rt_r_ff[SQ_STEPS-1][DW-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dd_in[i] = (DIV_W'(rt_a_ff[SQ_STEPS-1][i]) << FRAC_BITS) + DIV_W'(m_w >> 1);
      end
   end

   always_comb begin
      logic [DIV_W-1:0] rp;
      logic [QB-1:0]    qp;
      logic [DIV_W-1:0] d;
      for (int j = 0; j < QB; j++) begin
         for (int i = 0; i < 3; i++) begin
            if (j == 0) begin
               rp = dd_ff[i];
               qp = '0;
               d  = DIV_W'(dm_ff) << (QB - 1);
            end else begin
               rp = dq_r_ff[j-1][i];
               qp = dq_q_ff[j-1][i];
               d  = DIV_W'(dq_m_ff[j-1]) << (QB - 1 - j);
            end
            if (rp >= d) begin
               dq_r_in[j][i] = rp - d;
               dq_q_in[j][i] = {qp[QB-2:0], 1'b1};
            end else begin
               dq_r_in[j][i] = rp;
               dq_q_in[j][i] = {qp[QB-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dq_z_ff[QB-1]) begin
            o_in[i] = '0;
         end else if (dq_s_ff[QB-1][i]) begin
            o_in[i] = -nv_type'({1'b0, dq_q_ff[QB-1][i]});
         end else begin
            o_in[i] = nv_type'({1'b0, dq_q_ff[QB-1][i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NRM_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         w_ff[i]  <= w_in[i];
         a1_ff[i] <= a1_in[i];
         sq_ff[i] <= sq_in[i];
         sg1_ff[i] <= w_ff[i][DW-1];
         a2_ff[i] <= a1_ff[i];
         dd_ff[i] <= dd_in[i];
         o_ff[i]  <= o_in[i];
      end
      sg2_ff <= sg1_ff;
      sum_ff <= sum_in;
      for (int k = 0; k < SQ_STEPS; k++) begin
         rt_n_ff[k] <= rt_n_in[k];
         rt_r_ff[k] <= rt_r_in[k];
         if (k == 0) begin
            rt_a_ff[k] <= a2_ff;
            rt_s_ff[k] <= sg2_ff;
         end else begin
            rt_a_ff[k] <= rt_a_ff[k-1];
            rt_s_ff[k] <= rt_s_ff[k-1];
         end
      end
      dm_ff <= m_w;
      ds_ff <= rt_s_ff[SQ_STEPS-1];
      dz_ff <= (m_w == '0);
      for (int j = 0; j < QB; j++) begin
         dq_r_ff[j] <= dq_r_in[j];
         dq_q_ff[j] <= dq_q_in[j];
         if (j == 0) begin
            dq_m_ff[j] <= dm_ff;
            dq_s_ff[j] <= ds_ff;
            dq_z_ff[j] <= dz_ff;
         end else begin
            dq_m_ff[j] <= dq_m_ff[j-1];
            dq_s_ff[j] <= dq_s_ff[j-1];
            dq_z_ff[j] <= dq_z_ff[j-1];
         end
      end
   end

   assign out_valid = vld_ff[NRM_LAT-1];
   assign out_vec   = o_ff;

endmodule

[rtl/core/lav_cross.sv]
// ---------------------------------------------------------------------------
// Cross product
// Six registered products, then the differences scaled back to Q18.16.
// ---------------------------------------------------------------------------
module lav_cross (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  lav_pkg::nvec_type a,
   input  lav_pkg::fvec_type b,
   output logic              out_valid,
   output lav_pkg::xvec_type r
);
   import lav_pkg::*;

   logic [XP_LAT-1:0]      vld_ff;
   logic signed [PR_W-1:0] p_ff [6];
   logic signed [PR_W:0]   d_in [3];
   xp_type                 r_ff [3];

   always_comb begin
      d_in[0] = (PR_W+1)'(p_ff[0]) - (PR_W+1)'(p_ff[1]);
      d_in[1] = (PR_W+1)'(p_ff[2]) - (PR_W+1)'(p_ff[3]);
      d_in[2] = (PR_W+1)'(p_ff[4]) - (PR_W+1)'(p_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[XP_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      p_ff[0] <= a[1] * b[2];
      p_ff[1] <= a[2] * b[1];
      p_ff[2] <= a[2] * b[0];
      p_ff[3] <= a[0] * b[2];
      p_ff[4] <= a[0] * b[1];
      p_ff[5] <= a[1] * b[0];
      for (int i = 0; i < 3; i++) begin
         r_ff[i] <= XP_W'(d_in[i] >>> FRAC_BITS);
      end
   end

   assign out_valid = vld_ff[XP_LAT-1];
   assign r         = r_ff;

endmodule

[rtl/core/lav_dot.sv]
// ---------------------------------------------------------------------------
// Negated dot product
// Three registered products, a scaled sum, then negation and saturation.
// ---------------------------------------------------------------------------
module lav_dot (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  lav_pkg::nvec_type a,
   input  lav_pkg::fvec_type b,
   output logic              out_valid,
   output lav_pkg::fix_type  r
);
   import lav_pkg::*;

   logic [DOT_LAT-1:0]      vld_ff;
   logic signed [PR_W-1:0]  p_ff [3];
   logic signed [PR_W+1:0]  s_in;
   logic signed [SAT_W-1:0] s_ff;
   fix_type                 r_ff;

   assign s_in = (PR_W+2)'(p_ff[0]) + (PR_W+2)'(p_ff[1]) + (PR_W+2)'(p_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DOT_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         p_ff[i] <= a[i] * b[i];
      end
      s_ff <= SAT_W'(s_in >>> FRAC_BITS);
      r_ff <= sat_fix(-s_ff);
   end

   assign out_valid = vld_ff[DOT_LAT-1];
   assign r         = r_ff;

endmodule

[bench/look_at_view_matrix_tb.sv]
// ---------------------------------------------------------------------------
// Look-at view matrix testbench
// Sends camera requests, directed and in random bursts, and predicts the four
// matrix rows of each. Every result row is checked field by field, in order.
// ---------------------------------------------------------------------------
module look_at_view_matrix_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lav_pkg::*;

   typedef struct {
      logic [1:0] row;
      fix_type    c0, c1, c2, c3;
      logic       last;
   } row_type;

   typedef longint vec_type [3];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   fix_type req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   fix_type req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   fix_type req_up_x = '0, req_up_y = '0, req_up_z = '0;
   logic rsp_strobe, rsp_last_row;
   logic [1:0] rsp_row_index;
   fix_type rsp_col0, rsp_col1, rsp_col2, rsp_col3;

   row_type pending_rows[$];
   int mismatches = 0;

   look_at_view_matrix uut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res = 0, b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic void make_unit(ref vec_type v);
      longint w[3];
      longint unsigned a, sum, m, q;
      int s;
      bit fits;
      s = 0;
      forever begin
         fits = 1'b1;
         for (int i = 0; i < 3; i++) begin
            w[i] = v[i] >>> s;
            if (w[i] >= (64'sd1 <<< 31) || w[i] < -(64'sd1 <<< 31)) fits = 1'b0;
         end
         if (fits || s >= 40) break;
         s++;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         a = (w[i] < 0) ? -w[i] : w[i];
         sum += a * a;
      end
      if (sum == 0) return;
      m = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         a = (w[i] < 0) ? -w[i] : w[i];
         q = ((a << FRAC_BITS) + (m >> 1)) / m;
         v[i] = (w[i] < 0) ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic void cross_fix(input vec_type a, input vec_type b, ref vec_type r);
      r[0] = (a[1] * b[2] - a[2] * b[1]) >>> FRAC_BITS;
      r[1] = (a[2] * b[0] - a[0] * b[2]) >>> FRAC_BITS;
      r[2] = (a[0] * b[1] - a[1] * b[0]) >>> FRAC_BITS;
   endfunction

   function automatic fix_type clamp(input longint x);
      if (x > 64'sd2147483647) return 32'h7fffffff;
      if (x < -64'sd2147483648) return 32'h80000000;
      return fix_type'(x);
   endfunction

   function automatic fix_type neg_dot(input vec_type a, input vec_type b);
      longint d;
      d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      return clamp(-(d >>> FRAC_BITS));
   endfunction

   task automatic predict_matrix(input fix_type f[9]);
      vec_type eye, fwd, up, side, top;
      row_type r;
      for (int i = 0; i < 3; i++) begin
         eye[i] = f[i];
         fwd[i] = f[3 + i];
         up[i] = f[6 + i];
      end
      make_unit(fwd);
      cross_fix(fwd, up, side);
      make_unit(side);
      cross_fix(fwd, side, top);
      for (int k = 0; k < 3; k++) begin
         r.row = k[1:0];
         r.c0 = clamp(side[k]);
         r.c1 = clamp(top[k]);
         r.c2 = clamp(fwd[k]);
         r.c3 = '0;
         r.last = 1'b0;
         pending_rows.push_back(r);
      end
      r.row = ROW_LAST;
      r.c0 = neg_dot(side, eye);
      r.c1 = neg_dot(top, eye);
      r.c2 = neg_dot(fwd, eye);
      r.c3 = ONE_FIX;
      r.last = 1'b1;
      pending_rows.push_back(r);
   endtask

   always @(posedge clock) begin
      row_type e;
      if (!reset && rsp_strobe) begin
         if (pending_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected row %0d", rsp_row_index);
         end else begin
            e = pending_rows.pop_front();
            if (e.row !== rsp_row_index || e.c0 !== rsp_col0 || e.c1 !== rsp_col1 ||
                e.c2 !== rsp_col2 || e.c3 !== rsp_col3 || e.last !== rsp_last_row) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("row mismatch: exp %0d %h %h %h %h %b, got %0d %h %h %h %h %b",
                           e.row, e.c0, e.c1, e.c2, e.c3, e.last, rsp_row_index,
                           rsp_col0, rsp_col1, rsp_col2, rsp_col3, rsp_last_row);
            end
         end
      end
   end

   task automatic send_request(input fix_type f[9]);
      start <= 1'b1;
      req_eye_x <= f[0]; req_eye_y <= f[1]; req_eye_z <= f[2];
      req_dir_x <= f[3]; req_dir_y <= f[4]; req_dir_z <= f[5];
      req_up_x <= f[6]; req_up_y <= f[7]; req_up_z <= f[8];
      do @(posedge clock); while (busy);
      predict_matrix(f);
   endtask

   task automatic pause(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
   endtask

   function automatic fix_type rand_value;
      case ($urandom_range(0, 5))
         0: return fix_type'($urandom);
         1: return fix_type'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         2: return '0;
         3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return fix_type'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      endcase
   endfunction

   task automatic test_directed;
      fix_type f[9];
      f = '{0, 0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0};
      send_request(f);
      f = '{32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h80000000, 32'h80000000, 32'h80000000};
      send_request(f);
      f = '{32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000, 32'h80000000, 32'h80000000,
            32'h7fffffff, 0, 32'h80000000};
      send_request(f);
      f = '{32'h10000, 32'h20000, 32'h30000, 0, 0, 0, 0, 32'h10000, 0};
      send_request(f);
      f = '{32'h10000, 32'h20000, 32'h30000, 32'h10000, 0, 0, 0, 0, 0};
      send_request(f);
      f = '{32'h50000, 32'h7fffffff, 32'h80000000,
            32'h20000, 32'h40000, 32'h60000, 32'h10000, 32'h20000, 32'h30000};
      send_request(f);
      f = '{32'hffff0000, 32'h1, 32'hffffffff,
            32'h1, 0, 0, 0, 32'h7fffffff, 32'h80000000};
      send_request(f);
      f = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
      send_request(f);
      f = '{32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f,
            32'hfffe0000, 32'h00008000, 32'h00030000,
            32'h00000001, 32'h0, 32'h0};
      send_request(f);
      pause(3);
   endtask

   task automatic test_random(input int count);
      fix_type f[9];
      int sent = 0;
      while (sent < count) begin
         repeat ($urandom_range(1, 12)) begin
            for (int i = 0; i < 9; i++) f[i] = rand_value();
            if ($urandom_range(0, 7) == 0) begin
               for (int i = 6; i < 9; i++) f[i] = f[i - 3];
            end
            if ($urandom_range(0, 9) == 0) begin
               f[3] = '0; f[4] = '0; f[5] = '0;
            end
            send_request(f);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 20));
      end
   endtask

   task automatic test_pressure;
      drain();
      pause($urandom_range(1, 10));
      test_random(20);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(100);
      test_pressure();
      test_random(100);
      drain();
      pause(150);
      if (mismatches == 0 && pending_rows.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
